// File: rtl/mersenne_twister_generator_macros.svh
// ---------------------------------------------------------------------------
// mersenne_twister_generator_macros.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// checked only outside reset
`define MTG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset too
`define MTG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/mtg_pkg.sv
// ---------------------------------------------------------------------------
// mtg_pkg
// Constants, command types and tempering for the MT19937 generator.
// ---------------------------------------------------------------------------
package mtg_pkg;

   localparam int STATE_WORDS   = 624;
   localparam int MIDDLE_OFFSET = 397;
   localparam int KEY_WORDS     = 16;

   localparam int IDX_W = $clog2(STATE_WORDS + 1);
   localparam int KA_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int KC_W  = $clog2(KEY_WORDS + 1);

   localparam logic [31:0] MATRIX_A      = 32'h9908b0df;
   localparam logic [31:0] INIT_MULT     = 32'd1812433253;
   localparam logic [31:0] KEY_MULT_A    = 32'd1664525;
   localparam logic [31:0] KEY_MULT_B    = 32'd1566083941;
   localparam logic [31:0] KEY_BASE_SEED = 32'd19650218;
   localparam logic [31:0] TEMPER_B      = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C      = 32'hefc60000;
   localparam logic [31:0] UPPER_MASK    = 32'h80000000;
   localparam logic [31:0] LOWER_MASK    = 32'h7fffffff;

   // request modes as they arrive on the bus
   localparam logic [1:0] MODE_DRAW = 2'd0;
   localparam logic [1:0] MODE_SEED = 2'd1;
   localparam logic [1:0] MODE_KEY  = 2'd2;

   typedef enum logic [1:0] {
      OP_DRAW,
      OP_SEED,
      OP_KEY
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] data;
      logic        last;
   } cmd_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// File: rtl/mersenne_twister_generator.sv
// ---------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator: draws, single-word seeding and key-array seeding.
// ---------------------------------------------------------------------------
// After reset a clearing pass zeroes the 624-word state RAM, one word a cycle,
// with req_tready low. Requests go through a two-entry command queue into a
// sequencer that owns the single-read-port state RAM. A draw reads in S_DRAW_RD
// and is tempered into the registered beat in S_DRAW_OUT, which waits while the
// last beat is held; every 624th draw first runs a twist pass, with S_TW_LO,
// S_TW_MD and S_TW_WR per word for the two RAM reads each word needs. A seed
// runs a fill pass (S_FS_MUL, S_FS_WR per word) plus a twist; a final key word
// adds two more key passes. Key words that do not end a key are only stored.
// ---------------------------------------------------------------------------
module mersenne_twister_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [1:0] mode, [33:2] data_word, [39:34] zero
   input  logic        req_tlast,  // key_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [31:0] random_word
);

   logic             cmd_valid, cmd_pop, clearing;
   mtg_pkg::cmd_type cmd;

   mtg_front u_front (
      .clock (clock), .reset (reset),
      .req_tvalid (req_tvalid), .req_tready (req_tready),
      .req_tdata (req_tdata), .req_tlast (req_tlast),
      .hold (clearing), .cmd_valid (cmd_valid), .cmd (cmd), .cmd_pop (cmd_pop)
   );

   mtg_engine u_engine (
      .clock (clock), .reset (reset),
      .cmd_valid (cmd_valid), .cmd (cmd), .cmd_pop (cmd_pop), .clearing (clearing),
      .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready), .rsp_tdata (rsp_tdata)
   );

endmodule

// File: rtl/mtg_ram.sv
// ---------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mtg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/mtg_front.sv
// ---------------------------------------------------------------------------
// mtg_front
// Accepts request beats, turns them into commands and queues them.
// ---------------------------------------------------------------------------
module mtg_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,  // [1:0] mode, [33:2] data_word, zero fill
   input  logic             req_tlast,  // key_last
   input  logic             hold,
   output logic             cmd_valid,
   output mtg_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   mtg_pkg::cmd_type slot_ff [2];
   mtg_pkg::cmd_type slot_in [2];
   logic [1:0]       count_ff, count_in;
   logic             push;
   mtg_pkg::cmd_type new_cmd;
   logic             known;

   assign req_tready = (count_ff != 2'd2) && !hold;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = slot_ff[0];

   always_comb begin
      new_cmd.data = req_tdata[33:2];
      new_cmd.last = req_tlast;
      known        = 1'b1;
      case (req_tdata[1:0])
         mtg_pkg::MODE_DRAW: new_cmd.op = mtg_pkg::OP_DRAW;
         mtg_pkg::MODE_SEED: new_cmd.op = mtg_pkg::OP_SEED;
         mtg_pkg::MODE_KEY:  new_cmd.op = mtg_pkg::OP_KEY;
         default: begin
            new_cmd.op = mtg_pkg::OP_DRAW;
            known      = 1'b0;  // unused mode: beat is taken and dropped
         end
      endcase
   end

   assign push = req_tvalid && req_tready && known;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (cmd_pop && cmd_valid) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = new_cmd;
         count_in             = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/mtg_engine.sv
// ---------------------------------------------------------------------------
// mtg_engine
// Sequencer over the state RAM: clear, seeding, twist and draws.
// ---------------------------------------------------------------------------
module mtg_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  mtg_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             clearing,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata
);

   localparam int IW = mtg_pkg::IDX_W;
   localparam int KW = mtg_pkg::KC_W;
   localparam int AW = (mtg_pkg::STATE_WORDS > 1) ? $clog2(mtg_pkg::STATE_WORDS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(mtg_pkg::STATE_WORDS - 1);

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_DRAW_RD, S_DRAW_OUT,
      S_TW_INIT, S_TW_CUR, S_TW_LO, S_TW_MD, S_TW_WR,
      S_FS_MUL, S_FS_WR,
      S_K1_RD, S_K1_WR, S_K1_WRAP, S_K2_RD, S_K2_WR, S_K2_WRAP, S_K_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in, pos_ff, pos_in, rem_ff, rem_in, kcnt_ff, kcnt_in;
   logic [31:0]       cur_ff, cur_in, lo_ff, lo_in, p_ff, p_in, prod_ff, prod_in;
   logic [KW-1:0]     j_ff, j_in, len_ff, len_in, keycnt_ff, keycnt_in, cnt_next;
   logic              key_mode_ff, key_mode_in, draw_after_ff, draw_after_in;
   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_data_ff, out_data_in;

   logic              m_we, k_we;
   logic [AW-1:0]     m_waddr, m_raddr;
   logic [31:0]       m_wdata, m_rdata, k_rdata, v, y, px;
   logic [IW:0]       md_sum;
   logic [IW-1:0]     md, nx;
   logic [mtg_pkg::KA_W-1:0] k_waddr;

   mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::STATE_WORDS)) u_state_ram (
      .clock (clock), .we (m_we), .waddr (m_waddr), .wdata (m_wdata),
      .raddr (m_raddr), .rdata (m_rdata)
   );

   mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::KEY_WORDS)) u_key_ram (
      .clock (clock), .we (k_we), .waddr (k_waddr), .wdata (cmd.data),
      .raddr (j_ff[mtg_pkg::KA_W-1:0]), .rdata (k_rdata)
   );

   assign clearing   = (state_ff == S_CLR);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // twist neighbors, wrapping around the store
   assign md_sum = {1'b0, idx_ff} + (IW+1)'(mtg_pkg::MIDDLE_OFFSET);
   assign md     = (md_sum >= (IW+1)'(mtg_pkg::STATE_WORDS))
                   ? IW'(md_sum - (IW+1)'(mtg_pkg::STATE_WORDS)) : md_sum[IW-1:0];
   assign nx     = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign px     = p_ff ^ (p_ff >> 30);
   assign y      = (cur_ff & mtg_pkg::UPPER_MASK) | (lo_ff & mtg_pkg::LOWER_MASK);
   assign cnt_next = (keycnt_ff < KW'(mtg_pkg::KEY_WORDS)) ? keycnt_ff + 1'b1 : keycnt_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      kcnt_in       = kcnt_ff;
      cur_in        = cur_ff;
      lo_in         = lo_ff;
      p_in          = p_ff;
      prod_in       = prod_ff;
      j_in          = j_ff;
      len_in        = len_ff;
      keycnt_in     = keycnt_ff;
      key_mode_in   = key_mode_ff;
      draw_after_in = draw_after_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      cmd_pop       = 1'b0;
      m_we          = 1'b0;
      m_waddr       = idx_ff[AW-1:0];
      m_wdata       = '0;
      m_raddr       = idx_ff[AW-1:0];
      k_we          = 1'b0;
      k_waddr       = keycnt_ff[mtg_pkg::KA_W-1:0];
      v             = '0;

      case (state_ff)
         S_CLR: begin
            m_we = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  mtg_pkg::OP_DRAW: begin
                     if (rem_ff == '0 || pos_ff >= IW'(mtg_pkg::STATE_WORDS)) begin
                        draw_after_in = 1'b1;
                        state_in      = S_TW_INIT;
                     end else begin
                        state_in = S_DRAW_RD;
                     end
                  end
                  mtg_pkg::OP_SEED: begin
                     m_we        = 1'b1;
                     m_waddr     = '0;
                     m_wdata     = cmd.data;
                     p_in        = cmd.data;
                     idx_in      = IW'(1);
                     key_mode_in = 1'b0;
                     state_in    = S_FS_MUL;
                  end
                  mtg_pkg::OP_KEY: begin
                     k_we      = (keycnt_ff < KW'(mtg_pkg::KEY_WORDS));
                     keycnt_in = cnt_next;
                     if (cmd.last) begin
                        len_in      = cnt_next;
                        keycnt_in   = '0;
                        m_we        = 1'b1;
                        m_waddr     = '0;
                        m_wdata     = mtg_pkg::KEY_BASE_SEED;
                        p_in        = mtg_pkg::KEY_BASE_SEED;
                        idx_in      = IW'(1);
                        key_mode_in = 1'b1;
                        state_in    = S_FS_MUL;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DRAW_RD: begin
            m_raddr  = pos_ff[AW-1:0];
            state_in = S_DRAW_OUT;
         end
         S_DRAW_OUT: begin
            m_raddr = pos_ff[AW-1:0];
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = mtg_pkg::temper(m_rdata);
               pos_in       = pos_ff + 1'b1;
               rem_in       = rem_ff - 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TW_INIT: begin
            m_raddr  = '0;
            idx_in   = '0;
            state_in = S_TW_CUR;
         end
         S_TW_CUR: begin
            cur_in   = m_rdata;
            state_in = S_TW_LO;
         end
         S_TW_LO: begin
            m_raddr  = nx[AW-1:0];
            state_in = S_TW_MD;
         end
         S_TW_MD: begin
            m_raddr  = md[AW-1:0];
            lo_in    = m_rdata;
            state_in = S_TW_WR;
         end
         S_TW_WR: begin
            v       = m_rdata ^ (y >> 1) ^ (lo_ff[0] ? mtg_pkg::MATRIX_A : 32'd0);
            m_we    = 1'b1;
            m_wdata = v;
            cur_in  = lo_ff;
            if (idx_ff == LAST_IDX) begin
               pos_in        = '0;
               rem_in        = IW'(mtg_pkg::STATE_WORDS);
               draw_after_in = 1'b0;
               state_in      = draw_after_ff ? S_DRAW_RD : S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TW_LO;
            end
         end
         S_FS_MUL: begin
            prod_in  = mtg_pkg::INIT_MULT * px;
            state_in = S_FS_WR;
         end
         S_FS_WR: begin
            v       = prod_ff + 32'(idx_ff);
            m_we    = 1'b1;
            m_wdata = v;
            p_in    = v;
            if (idx_ff == LAST_IDX) begin
               if (key_mode_ff) begin
                  idx_in   = IW'(1);
                  j_in     = '0;
                  p_in     = mtg_pkg::KEY_BASE_SEED;
                  kcnt_in  = IW'(mtg_pkg::STATE_WORDS);
                  state_in = S_K1_RD;
               end else begin
                  draw_after_in = 1'b0;
                  state_in      = S_TW_INIT;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_FS_MUL;
            end
         end
         S_K1_RD: begin
            prod_in  = px * mtg_pkg::KEY_MULT_A;
            state_in = S_K1_WR;
         end
         S_K1_WR: begin
            v       = (m_rdata ^ prod_ff) + k_rdata + 32'(j_ff);
            m_we    = 1'b1;
            m_wdata = v;
            p_in    = v;
            kcnt_in = kcnt_ff - 1'b1;
            j_in    = ((j_ff + 1'b1) >= len_ff) ? '0 : j_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_K1_WRAP;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (kcnt_ff == IW'(1)) begin
                  kcnt_in  = LAST_IDX;
                  state_in = S_K2_RD;
               end else begin
                  state_in = S_K1_RD;
               end
            end
         end
         S_K1_WRAP: begin
            m_we    = 1'b1;
            m_waddr = '0;
            m_wdata = p_ff;
            idx_in  = IW'(1);
            if (kcnt_ff == '0) begin
               kcnt_in  = LAST_IDX;
               state_in = S_K2_RD;
            end else begin
               state_in = S_K1_RD;
            end
         end
         S_K2_RD: begin
            prod_in  = px * mtg_pkg::KEY_MULT_B;
            state_in = S_K2_WR;
         end
         S_K2_WR: begin
            v       = (m_rdata ^ prod_ff) - 32'(idx_ff);
            m_we    = 1'b1;
            m_wdata = v;
            p_in    = v;
            kcnt_in = kcnt_ff - 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_K2_WRAP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = (kcnt_ff == IW'(1)) ? S_K_FIN : S_K2_RD;
            end
         end
         S_K2_WRAP: begin
            m_we     = 1'b1;
            m_waddr  = '0;
            m_wdata  = p_ff;
            idx_in   = IW'(1);
            state_in = (kcnt_ff == '0) ? S_K_FIN : S_K2_RD;
         end
         S_K_FIN: begin
            m_we          = 1'b1;
            m_waddr       = '0;
            m_wdata       = mtg_pkg::UPPER_MASK;
            draw_after_in = 1'b0;
            state_in      = S_TW_INIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      lo_ff       <= lo_in;
      p_ff        <= p_in;
      prod_ff     <= prod_in;
      j_ff        <= j_in;
      len_ff      <= len_in;
      kcnt_ff     <= kcnt_in;
      key_mode_ff <= key_mode_in;
      out_data_ff <= out_data_in;
      if (reset) begin
         state_ff      <= S_CLR;
         idx_ff        <= '0;
         pos_ff        <= '0;
         rem_ff        <= '0;
         keycnt_ff     <= '0;
         draw_after_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pos_ff        <= pos_in;
         rem_ff        <= rem_in;
         keycnt_ff     <= keycnt_in;
         draw_after_ff <= draw_after_in;
         out_valid_ff  <= out_valid_in;
      end
   end

endmodule

// File: rtl/mtg_checker.sv
// ---------------------------------------------------------------------------
// mtg_checker
// Port-level checks for the generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "mersenne_twister_generator_macros.svh"

module mtg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   `MTG_ASSERT(rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp beat dropped")
   `MTG_ASSERT(rsp_data_hold, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp data moved")
   `MTG_ASSERT_ALWAYS(no_rsp_after_reset, reset |=> !rsp_tvalid, "rsp valid after reset")
   `MTG_ASSERT_ALWAYS(clear_blocks_req, reset |=> !req_tready, "req taken during clear")

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
   .clock (clock), .reset (reset),
   .req_tvalid (req_tvalid), .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready), .rsp_tdata (rsp_tdata)
);

// File: verif/mersenne_twister_generator_test.sv
// ---------------------------------------------------------------------------
// mersenne_twister_generator_test
// Self-checking regression for the MT19937 generator.
// ---------------------------------------------------------------------------
// Drives draw, single-seed and key-word beats on the request stream and checks
// every response beat against a behavioral MT19937 model kept in the bench.
// A directed table covers reset-state draws, seed extremes, key overflow and
// unused modes; random sequences follow, with random idling on both sides
// and one long response stall that backs up the request queue.
// ---------------------------------------------------------------------------
module mersenne_twister_generator_test;

   localparam int NUM_RANDOM = 1925;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] data;
      logic        last;
      logic        check_word;
      logic [31:0] word;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   // bench copy of the generator state
   logic [31:0] mt_words [mtg_pkg::STATE_WORDS];
   int          mt_pos;
   int          mt_left;
   logic [31:0] key_words [mtg_pkg::KEY_WORDS];
   int          key_held;

   logic [31:0] word_queue [$];
   int          errors = 0;
   int          draws = 0;
   int          seeds = 0;
   int          keys = 0;
   bit          quiet = 1'b0;
   bit          hold_off = 1'b0;
   bit          hold_done = 1'b0;

   stim_row_type rows [$];

   mersenne_twister_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] scramble(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      return y ^ (y >> 18);
   endfunction

   task automatic twist_store();
      int          nx;
      int          md;
      logic [31:0] y;
      logic [31:0] v;
      for (int k = 0; k < mtg_pkg::STATE_WORDS; k++) begin
         nx = (k + 1) % mtg_pkg::STATE_WORDS;
         md = (k + mtg_pkg::MIDDLE_OFFSET) % mtg_pkg::STATE_WORDS;
         y  = (mt_words[k] & 32'h80000000) | (mt_words[nx] & 32'h7fffffff);
         v  = mt_words[md] ^ (y >> 1);
         if (mt_words[nx][0]) v = v ^ 32'h9908b0df;
         mt_words[k] = v;
      end
      mt_pos  = 0;
      mt_left = mtg_pkg::STATE_WORDS;
   endtask

   task automatic fill_store(input logic [31:0] seed);
      logic [31:0] p;
      mt_words[0] = seed;
      for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
         p = mt_words[i-1];
         mt_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
      end
   endtask

   task automatic key_seed(input int len);
      int          i;
      int          j;
      int          n;
      logic [31:0] p;
      logic [31:0] kw;
      i = 1;
      j = 0;
      fill_store(32'd19650218);
      n = (mtg_pkg::STATE_WORDS > len) ? mtg_pkg::STATE_WORDS : len;
      for (; n > 0; n--) begin
         p  = mt_words[i-1];
         kw = (j < mtg_pkg::KEY_WORDS) ? key_words[j] : 32'd0;
         mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1664525)) + kw + 32'(j);
         i++;
         j++;
         if (i >= mtg_pkg::STATE_WORDS) begin
            mt_words[0] = mt_words[mtg_pkg::STATE_WORDS-1];
            i = 1;
         end
         if (j >= len) j = 0;
      end
      for (n = mtg_pkg::STATE_WORDS - 1; n > 0; n--) begin
         p = mt_words[i-1];
         mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - 32'(i);
         i++;
         if (i >= mtg_pkg::STATE_WORDS) begin
            mt_words[0] = mt_words[mtg_pkg::STATE_WORDS-1];
            i = 1;
         end
      end
      mt_words[0] = 32'h80000000;
      twist_store();
   endtask

   // advance the bench state by one accepted beat; returns 1 for a draw
   task automatic predict_beat(input logic [1:0] mode, input logic [31:0] data,
                               input logic last, output bit drew,
                               output logic [31:0] word);
      drew = 1'b0;
      word = '0;
      case (mode)
         mtg_pkg::MODE_DRAW: begin
            if (mt_left == 0 || mt_pos >= mtg_pkg::STATE_WORDS) twist_store();
            mt_left--;
            word = scramble(mt_words[mt_pos]);
            mt_pos++;
            drew = 1'b1;
            draws++;
         end
         mtg_pkg::MODE_SEED: begin
            fill_store(data);
            twist_store();
            seeds++;
         end
         mtg_pkg::MODE_KEY: begin
            if (key_held < mtg_pkg::KEY_WORDS) begin
               key_words[key_held] = data;
               key_held++;
            end
            if (last) begin
               key_seed(key_held);
               key_held = 0;
               keys++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_beat(input logic [1:0] mode, input logic [31:0] data,
                            input logic last, input bit has_word,
                            input logic [31:0] typed_word);
      bit          drew;
      logic [31:0] word;
      int          gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 13);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, data, mode};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beat(mode, data, last, drew, word);
      if (drew) begin
         if (has_word && typed_word !== word) begin
            $display("%0t: table row disagrees with model: expected %h got %h",
                     $time, typed_word, word);
            errors++;
         end
         word_queue.push_back(word);
      end
   endtask

   task automatic add_row(input logic [1:0] mode, input logic [31:0] data,
                          input logic last, input bit known, input logic [31:0] word);
      stim_row_type r;
      r.mode = mode;
      r.data = data;
      r.last = last;
      r.check_word = known;
      r.word = word;
      rows.push_back(r);
   endtask

   // response side: random stalls, one long hold-off
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (word_queue.size() == 0) begin
            $display("%0t: unexpected response beat: expected none got %h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            if (rsp_tdata !== word_queue[0]) begin
               $display("%0t: random_word mismatch: expected %h got %h",
                        $time, word_queue[0], rsp_tdata);
               errors++;
            end
            void'(word_queue.pop_front());
         end
      end
   end

   initial begin
      #400000000;
      $display("mersenne_twister_generator regression: fail");
      $finish;
   end

   initial begin
      int          wait_cycles;
      int          nkey;
      int          sent;
      for (int i = 0; i < mtg_pkg::STATE_WORDS; i++) mt_words[i] = '0;
      for (int i = 0; i < mtg_pkg::KEY_WORDS; i++) key_words[i] = '0;
      mt_pos = 0;
      mt_left = 0;
      key_held = 0;

      // draws before seeding give zero
      add_row(mtg_pkg::MODE_DRAW, 32'hffffffff, 1'b1, 1'b1, 32'd0);
      add_row(mtg_pkg::MODE_DRAW, 32'd0, 1'b0, 1'b1, 32'd0);
      add_row(MODE_UNUSED, 32'hdeadbeef, 1'b1, 1'b0, '0);
      add_row(mtg_pkg::MODE_SEED, 32'd5489, 1'b1, 1'b0, '0);
      // well-known first outputs for the default seed
      add_row(mtg_pkg::MODE_DRAW, '0, 1'b0, 1'b1, 32'd3499211612);
      add_row(mtg_pkg::MODE_DRAW, '0, 1'b0, 1'b1, 32'd581869302);
      add_row(mtg_pkg::MODE_SEED, 32'd0, 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_DRAW, '0, 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_SEED, 32'hffffffff, 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_DRAW, '0, 1'b1, 1'b0, '0);
      // standard four-word key
      add_row(mtg_pkg::MODE_KEY, 32'h123, 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_KEY, 32'h234, 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_SEED, 32'h1, 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_KEY, 32'h345, 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_KEY, 32'h456, 1'b1, 1'b0, '0);
      add_row(mtg_pkg::MODE_DRAW, '0, 1'b0, 1'b1, 32'd1067595299);
      add_row(mtg_pkg::MODE_KEY, 32'hffffffff, 1'b1, 1'b0, '0);
      add_row(mtg_pkg::MODE_DRAW, '0, 1'b0, 1'b0, '0);
      // key overflow: 17 words then a dropped last word
      for (int i = 0; i < mtg_pkg::KEY_WORDS + 1; i++)
         add_row(mtg_pkg::MODE_KEY, 32'h1000 + 32'(i), 1'b0, 1'b0, '0);
      add_row(mtg_pkg::MODE_KEY, 32'h0, 1'b1, 1'b0, '0);
      add_row(mtg_pkg::MODE_DRAW, '0, 1'b0, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[r])
         send_beat(rows[r].mode, rows[r].data, rows[r].last, rows[r].check_word,
                   rows[r].word);

      sent = 0;
      while (sent < NUM_RANDOM) begin
         if (sent >= 300 && !hold_done) begin
            hold_off  = 1'b1;
            hold_done = 1'b1;
         end
         if (sent > NUM_RANDOM - 150) quiet = 1'b1;
         case ($urandom_range(0, 99)) inside
            [0:1]: begin
               send_beat(mtg_pkg::MODE_SEED, $urandom, 1'($urandom_range(0, 1)),
                         1'b0, '0);
               sent++;
            end
            [2:3]: begin
               nkey = $urandom_range(1, mtg_pkg::KEY_WORDS + 3);
               for (int i = 0; i < nkey; i++)
                  send_beat(mtg_pkg::MODE_KEY, $urandom, i == nkey - 1, 1'b0, '0);
               sent += nkey;
            end
            4: begin
               send_beat(MODE_UNUSED, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
               sent++;
            end
            5: begin
               send_beat(mtg_pkg::MODE_KEY, $urandom, 1'b0, 1'b0, '0);
               sent++;
            end
            default: begin
               send_beat(mtg_pkg::MODE_DRAW, $urandom, 1'($urandom_range(0, 1)),
                         1'b0, '0);
               sent++;
            end
         endcase
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (word_queue.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (3000) @(posedge clock);
      if (word_queue.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, word_queue.size());
         errors++;
      end
      $display("covered %0d draws, %0d single-word seeds, %0d key seedings",
               draws, seeds, keys);
      if (errors == 0)
         $display("mersenne_twister_generator regression: pass");
      else
         $display("mersenne_twister_generator regression: fail");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/mtg_pkg.sv
rtl/mtg_ram.sv
rtl/mtg_front.sv
rtl/mtg_engine.sv
rtl/mersenne_twister_generator.sv
rtl/mtg_checker.sv
verif/mersenne_twister_generator_test.sv
